[design/bop_pkg.sv]
// Package for the box overlap percentage unit: field widths, request and
// result types, and the records handed between the front end and the divider.
// No dependencies.
package bop_pkg;

	// Field widths of the request and result.
	localparam int COORD_BITS        = 16;
	localparam int PERCENT_FRAC_BITS = 8;
	localparam int SIZE_BITS         = COORD_BITS - 1;
	localparam int OUT_BITS          = 7 + PERCENT_FRAC_BITS;

	// Internal widths.
	localparam int END_BITS  = COORD_BITS + 1;
	localparam int AREA_BITS = 2 * SIZE_BITS;
	localparam int SU_BITS   = AREA_BITS + 1;
	localparam int NUM_BITS  = AREA_BITS + 7;
	localparam int REM_BITS  = SU_BITS + OUT_BITS;

	// Pipeline depth: four front-end stages, one cell per quotient bit, one output register.
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY      = FRONT_STAGES + OUT_BITS + 1;

	// Result for identical boxes: exactly 100 percent.
	localparam logic [OUT_BITS-1:0] PCT_FULL = OUT_BITS'(100 << PERCENT_FRAC_BITS);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_left;
		logic signed [COORD_BITS-1:0] a_top;
		logic [SIZE_BITS-1:0]         a_width;
		logic [SIZE_BITS-1:0]         a_height;
		logic signed [COORD_BITS-1:0] b_left;
		logic signed [COORD_BITS-1:0] b_top;
		logic [SIZE_BITS-1:0]         b_width;
		logic [SIZE_BITS-1:0]         b_height;
	} bop_req_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] overlap_percent;
		logic                boxes_touch;
	} bop_res_t;

	// Decisions made in the front end that ride along with the division.
	typedef struct packed {
		logic touch;
		logic ident;
		logic zero;
	} bop_flags_t;

	// Record passed from cell to cell of the divider chain.
	typedef struct packed {
		logic [REM_BITS-1:0] rem;
		logic [SU_BITS-1:0]  su;
		logic [OUT_BITS-1:0] quo;
		bop_flags_t          flags;
	} bop_div_t;

endpackage

[design/bop_front.sv]
// Front end of the box overlap percentage unit: box geometry, areas and the
// scaled dividend, in four pipeline stages. Depends on bop_pkg.
module bop_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bop_pkg::bop_req_t req,
	output logic              out_valid,
	output bop_pkg::bop_div_t out_rec
);

	localparam int EB = bop_pkg::END_BITS;
	localparam int SB = bop_pkg::SIZE_BITS;
	localparam int AB = bop_pkg::AREA_BITS;
	localparam logic [bop_pkg::NUM_BITS-1:0] PCT_SCALE = bop_pkg::NUM_BITS'(100);

	// Stage 1 inputs, widened so that corner plus size cannot overflow.
	logic signed [EB-1:0] ax, ay, bx, by;
	logic signed [EB-1:0] aw, ah, bw, bh;
	logic signed [EB-1:0] a_right, a_bottom, b_right, b_bottom;

	// Pipeline registers.
	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 touch_s1, ident_s1;
	logic signed [EB-1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;
	logic [SB-1:0]        aw_s1, ah_s1, bw_s1, bh_s1;
	logic                 touch_s2, ident_s2;
	logic [SB-1:0]        iw_s2, ih_s2, aw_s2, ah_s2, bw_s2, bh_s2;
	logic                 touch_s3, ident_s3;
	logic [AB-1:0]        si_s3, sa_s3, sb_s3;
	logic [bop_pkg::SU_BITS-1:0]  su_s4;
	logic [bop_pkg::NUM_BITS-1:0] num_s4;
	bop_pkg::bop_flags_t  flags_s4;

	// Stage 2 differences.
	logic signed [EB-1:0] dx, dy;

	always_comb begin
		ax       = EB'(req.a_left);
		ay       = EB'(req.a_top);
		bx       = EB'(req.b_left);
		by       = EB'(req.b_top);
		aw       = EB'(req.a_width);
		ah       = EB'(req.a_height);
		bw       = EB'(req.b_width);
		bh       = EB'(req.b_height);
		a_right  = ax + aw;
		a_bottom = ay + ah;
		b_right  = bx + bw;
		b_bottom = by + bh;
	end

	assign dx = hi_x_s1 - lo_x_s1;
	assign dy = hi_y_s1 - lo_y_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: closed-box contact test and the intersection edges.
		touch_s1 <= !(ax > b_right || bx > a_right) && !(ay > b_bottom || by > a_bottom);
		ident_s1 <= (req.a_left == req.b_left) && (req.a_top == req.b_top) &&
			(req.a_width == req.b_width) && (req.a_height == req.b_height);
		lo_x_s1  <= (ax > bx) ? ax : bx;
		hi_x_s1  <= (a_right < b_right) ? a_right : b_right;
		lo_y_s1  <= (ay > by) ? ay : by;
		hi_y_s1  <= (a_bottom < b_bottom) ? a_bottom : b_bottom;
		aw_s1    <= req.a_width;
		ah_s1    <= req.a_height;
		bw_s1    <= req.b_width;
		bh_s1    <= req.b_height;

		// Stage 2: intersection extent; touching boxes never give a negative one.
		touch_s2 <= touch_s1;
		ident_s2 <= ident_s1;
		iw_s2    <= touch_s1 ? dx[SB-1:0] : '0;
		ih_s2    <= touch_s1 ? dy[SB-1:0] : '0;
		aw_s2    <= aw_s1;
		ah_s2    <= ah_s1;
		bw_s2    <= bw_s1;
		bh_s2    <= bh_s1;

		// Stage 3: the three areas.
		touch_s3 <= touch_s2;
		ident_s3 <= ident_s2;
		si_s3    <= AB'(iw_s2) * AB'(ih_s2);
		sa_s3    <= AB'(aw_s2) * AB'(ah_s2);
		sb_s3    <= AB'(bw_s2) * AB'(bh_s2);

		// Stage 4: union area and the dividend scaled to percent.
		su_s4          <= bop_pkg::SU_BITS'(sa_s3) + bop_pkg::SU_BITS'(sb_s3)
			- bop_pkg::SU_BITS'(si_s3);
		num_s4         <= bop_pkg::NUM_BITS'(si_s3) * PCT_SCALE;
		flags_s4.touch <= touch_s3;
		flags_s4.ident <= ident_s3;
		flags_s4.zero  <= (sa_s3 == '0) && (sb_s3 == '0);
	end

	// The dividend enters the divider already shifted by the fraction bits.
	always_comb begin
		out_valid     = valid_s4;
		out_rec.rem   = bop_pkg::REM_BITS'(num_s4) << bop_pkg::PERCENT_FRAC_BITS;
		out_rec.su    = su_s4;
		out_rec.quo   = '0;
		out_rec.flags = flags_s4;
	end

endmodule

[design/bop_div_cell.sv]
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on bop_pkg.
module bop_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bop_pkg::bop_div_t in_rec,
	output logic              out_valid,
	output bop_pkg::bop_div_t out_rec
);

	localparam int RB = bop_pkg::REM_BITS;
	localparam int QB = bop_pkg::OUT_BITS;

	logic [RB-1:0]     dvs;
	logic              ge;
	logic [RB-1:0]     rem_sub;
	logic              valid_q;
	bop_pkg::bop_div_t rec_q;

	// Compare against the divisor aligned to the top quotient bit; the
	// remainder doubles after each step instead of the divisor shifting.
	always_comb begin
		dvs     = RB'(in_rec.su) << (QB - 1);
		ge      = in_rec.rem >= dvs;
		rem_sub = ge ? (in_rec.rem - dvs) : in_rec.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rec_q.rem   <= rem_sub << 1;
		rec_q.su    <= in_rec.su;
		rec_q.quo   <= {in_rec.quo[QB-2:0], ge};
		rec_q.flags <= in_rec.flags;
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

[design/box_overlap_percentage_unit.sv]
// Top level of the box overlap percentage unit: front end, divider chain
// and output register. Depends on bop_pkg, bop_front and bop_div_cell.
//
// Usage: drive a box pair on req and raise start; the request is taken at
// any rising edge with start high and busy low. busy stays low, so a new
// request may be given in every cycle, one pair per clock.
// The result appears on res with done high for exactly one cycle, after the
// request has passed four front-end stages for geometry, areas and the scaled
// dividend, one divider cell per quotient bit (15 cells), and the output register.
// The divider chain is the longest part of the pipeline; every stage takes
// a new request each cycle, so throughput is one result per clock.
// Results leave in request order. The receiver cannot stall the block and
// must take each result in the cycle that done marks.
// Reset clears every valid bit at once; requests in flight are dropped and
// no result is shown for them. No state survives between requests.
module box_overlap_percentage_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bop_pkg::bop_req_t req,
	output logic              done,
	output bop_pkg::bop_res_t res
);

	localparam int NCELL = bop_pkg::OUT_BITS;

	logic              chain_valid [NCELL+1];
	bop_pkg::bop_div_t chain_rec   [NCELL+1];
	bop_pkg::bop_div_t last_rec;
	logic              done_q;
	bop_pkg::bop_res_t res_q;

	// The pipeline never stalls.
	assign busy = 1'b0;

	bop_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.req      (req),
		.out_valid(chain_valid[0]),
		.out_rec  (chain_rec[0])
	);

	// Divider chain, one cell per quotient bit.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bop_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[i]),
			.in_rec   (chain_rec[i]),
			.out_valid(chain_valid[i+1]),
			.out_rec  (chain_rec[i+1])
		);
	end

	assign last_rec = chain_rec[NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_valid[NCELL];
		end
	end

	// Identical boxes: exactly full scale; else no contact or empty union: zero.
	always_ff @(posedge clk) begin
		res_q.boxes_touch <= last_rec.flags.touch;
		priority if (last_rec.flags.touch && last_rec.flags.ident) begin
			res_q.overlap_percent <= bop_pkg::PCT_FULL;
		end else if (!last_rec.flags.touch || last_rec.flags.zero) begin
			res_q.overlap_percent <= '0;
		end else begin
			res_q.overlap_percent <= last_rec.quo;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[design/bop_checker.sv]
// Port-level checks for the box overlap percentage unit, bound to its top
// level. Depends on bop_pkg and box_overlap_percentage_unit.
module bop_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input bop_pkg::bop_req_t req,
	input logic              done,
	input bop_pkg::bop_res_t res
);

	localparam int LAT = bop_pkg::LATENCY;

	// A result only ever follows a matching request taken earlier.
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	// Every request taken yields its result.
	a_request_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request taken but no result delivered");

	// Identical boxes always give full scale with contact.
	a_identical_full: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.a_left == req.b_left && req.a_top == req.b_top &&
		 req.a_width == req.b_width && req.a_height == req.b_height)
		|-> ##LAT (done && res.boxes_touch && res.overlap_percent == bop_pkg::PCT_FULL))
		else $error("identical boxes did not give full overlap");

	// Separate boxes have no overlap, and no result exceeds full scale.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.overlap_percent <= bop_pkg::PCT_FULL) &&
			(res.boxes_touch || res.overlap_percent == '0))
		else $error("overlap result out of range");

endmodule

bind box_overlap_percentage_unit bop_checker u_bop_checker (.*);
